>>> hdl/knn_pkg.sv
// Shared types and constants for the two-class nearest-neighbor vote block.
// Holds request, label and class codes and the controller/datapath interface structs.
// No dependencies.
package knn_pkg;

   // Request codes carried on req_type.
   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   // Training label codes.
   localparam logic [1:0] LABEL_RED  = 2'd0;
   localparam logic [1:0] LABEL_BLUE = 2'd1;

   // Answer codes on rsp_decided_class.
   localparam logic CLASS_RED  = 1'b0;
   localparam logic CLASS_BLUE = 1'b1;

   // Fixed field widths.
   localparam int LABEL_W = 2;
   localparam int NC_W    = 5;
   localparam int VOTE_W  = 5;
   localparam logic [NC_W-1:0] NC_RESET = 5'd1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic query;
      logic scan;
      logic count;
      logic finish;
   } knn_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic store_empty;
      logic scan_last;
      logic pipe_busy;
      logic count_done;
   } knn_status_type;

endpackage

>>> hdl/knn_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module knn_ram #(
   parameter int WIDTH = 34,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/knn_ctrl.sv
// Controller state machine of the nearest-neighbor vote block.
// Depends on knn_pkg for the command and status structs and the request codes.
module knn_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    req_type,
   input  knn_pkg::knn_status_type status,
   output knn_pkg::knn_cmd_type    cmd,
   output logic                    busy
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SCAN  = 5'b00010,
      ST_DRAIN = 5'b00100,
      ST_COUNT = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_type == knn_pkg::REQ_QUERY) begin
                  cmd.query = 1'b1;
                  state_in  = ST_SCAN;
               end else begin
                  cmd.load = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            if (status.store_empty) begin
               state_in = ST_DRAIN;
            end else begin
               cmd.scan = 1'b1;
               if (status.scan_last) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = ST_COUNT;
            end
         end
         ST_COUNT: begin
            if (status.count_done) begin
               state_in = ST_DONE;
            end else begin
               cmd.count = 1'b1;
            end
         end
         ST_DONE: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

>>> hdl/knn_datapath.sv
// Datapath of the nearest-neighbor vote block: point store, distance pipeline,
// sorted nearest list, vote counters and result register.
// Depends on knn_pkg and knn_ram.
module knn_datapath #(
   parameter int MAX_POINTS  = 256,
   parameter int MAX_K       = 16,
   parameter int COORD_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  knn_pkg::knn_cmd_type          cmd,
   output knn_pkg::knn_status_type       status,
   input  logic signed [COORD_WIDTH-1:0] req_coord_x,
   input  logic signed [COORD_WIDTH-1:0] req_coord_y,
   input  logic [knn_pkg::LABEL_W-1:0]   req_class_label,
   input  logic                          csr_write,
   input  logic [knn_pkg::NC_W-1:0]      csr_neighbor_count,
   output logic                          rsp_valid,
   output logic                          rsp_decided_class,
   output logic [knn_pkg::VOTE_W-1:0]    rsp_red_votes,
   output logic [knn_pkg::VOTE_W-1:0]    rsp_blue_votes
);

   localparam int AW     = $clog2(MAX_POINTS);
   localparam int PW     = $clog2(MAX_POINTS + 1);
   localparam int CW     = $clog2(MAX_K + 1);
   localparam int IW     = (MAX_K > 1) ? $clog2(MAX_K) : 1;
   localparam int LW     = knn_pkg::LABEL_W;
   localparam int ENT_W  = 2 * COORD_WIDTH + LW;
   localparam int DIFF_W = COORD_WIDTH + 1;
   localparam int SQ_W   = 2 * COORD_WIDTH;
   localparam int DIST_W = SQ_W + 1;

   // Configuration and query registers.
   logic [knn_pkg::NC_W-1:0] neighbor_count_ff;
   logic [CW-1:0]            kk_ff, kk_in;
   logic [COORD_WIDTH-1:0]   qx_ff, qy_ff;

   // Store bookkeeping.
   logic [PW-1:0] points_ff, points_in;
   logic [AW-1:0] scan_idx_ff, scan_idx_in;
   logic          store_wr;

   // RAM ports.
   logic [ENT_W-1:0] wr_data;
   logic [ENT_W-1:0] rd_data;

   // Distance pipeline.
   logic                   rd_vld_ff, mag_vld_ff, sq_vld_ff, dist_vld_ff;
   logic [COORD_WIDTH-1:0] mag_x_ff, mag_y_ff, mag_x_in, mag_y_in;
   logic [SQ_W-1:0]        sq_x_ff, sq_y_ff;
   logic [DIST_W-1:0]      dist_ff;
   logic [LW-1:0]          mag_label_ff, sq_label_ff, dist_label_ff;
   logic [DIFF_W-1:0]      diff_x, diff_y;

   // Sorted nearest list.
   logic [DIST_W-1:0] near_dist_ff  [MAX_K];
   logic [DIST_W-1:0] near_dist_in  [MAX_K];
   logic [LW-1:0]     near_label_ff [MAX_K];
   logic [LW-1:0]     near_label_in [MAX_K];
   logic [CW-1:0]     fill_ff, fill_in;
   logic [MAX_K-1:0]  lt, ins, ins_prev;
   logic              take;

   // Vote counting.
   logic [CW-1:0] cnt_idx_ff, red_ff, blue_ff;
   logic [LW-1:0] cnt_label;

   // Result register.
   logic                      rsp_valid_ff;
   logic                      rsp_class_ff;
   logic [knn_pkg::VOTE_W-1:0] rsp_red_ff, rsp_blue_ff;

   // Point store.
   assign store_wr = cmd.load && (points_ff < PW'(MAX_POINTS));
   assign wr_data  = {req_class_label, req_coord_y, req_coord_x};

   knn_ram #(
      .WIDTH (ENT_W),
      .DEPTH (MAX_POINTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_wr),
      .wr_addr (points_ff[AW-1:0]),
      .wr_data (wr_data),
      .rd_addr (scan_idx_ff),
      .rd_data (rd_data)
   );

   // Effective k is the register value limited to the list depth.
   always_comb begin
      if (32'(neighbor_count_ff) > 32'(MAX_K)) begin
         kk_in = CW'(MAX_K);
      end else begin
         kk_in = CW'(neighbor_count_ff);
      end
   end

   // Store fill count and scan address.
   always_comb begin
      points_in   = points_ff;
      scan_idx_in = scan_idx_ff;
      if (store_wr) begin
         points_in = points_ff + PW'(1);
      end
      if (cmd.query) begin
         scan_idx_in = '0;
      end else if (cmd.scan) begin
         scan_idx_in = scan_idx_ff + AW'(1);
      end
      if (cmd.finish) begin
         points_in = '0;
      end
   end

   // Absolute coordinate differences; each magnitude fits the coordinate width.
   always_comb begin
      diff_x = {qx_ff[COORD_WIDTH-1], qx_ff}
             - {rd_data[COORD_WIDTH-1], rd_data[COORD_WIDTH-1:0]};
      diff_y = {qy_ff[COORD_WIDTH-1], qy_ff}
             - {rd_data[2*COORD_WIDTH-1], rd_data[2*COORD_WIDTH-1:COORD_WIDTH]};
      if (diff_x[DIFF_W-1]) begin
         mag_x_in = COORD_WIDTH'(-diff_x);
      end else begin
         mag_x_in = diff_x[COORD_WIDTH-1:0];
      end
      if (diff_y[DIFF_W-1]) begin
         mag_y_in = COORD_WIDTH'(-diff_y);
      end else begin
         mag_y_in = diff_y[COORD_WIDTH-1:0];
      end
   end

   // Insertion compare: the list is sorted, so lt is a run of ones at the top.
   // An equal distance does not move ahead of an older entry.
   always_comb begin
      for (int j = 0; j < MAX_K; j++) begin
         lt[j]  = (fill_ff > CW'(j)) && (dist_ff < near_dist_ff[j]);
         ins[j] = lt[j] || (fill_ff == CW'(j));
      end
      ins_prev[0] = 1'b0;
      for (int j = 1; j < MAX_K; j++) begin
         ins_prev[j] = ins[j-1];
      end
      take = dist_vld_ff && ((fill_ff < kk_ff) || (|lt));
   end

   // Shift the tail down and drop the new point into its place.
   always_comb begin
      for (int j = 0; j < MAX_K; j++) begin
         near_dist_in[j]  = near_dist_ff[j];
         near_label_in[j] = near_label_ff[j];
      end
      if (take && ins[0]) begin
         near_dist_in[0]  = dist_ff;
         near_label_in[0] = dist_label_ff;
      end
      for (int j = 1; j < MAX_K; j++) begin
         if (take && (CW'(j) < kk_ff)) begin
            if (ins_prev[j]) begin
               near_dist_in[j]  = near_dist_ff[j-1];
               near_label_in[j] = near_label_ff[j-1];
            end else if (ins[j]) begin
               near_dist_in[j]  = dist_ff;
               near_label_in[j] = dist_label_ff;
            end
         end
      end
      fill_in = fill_ff;
      if (cmd.query || cmd.finish) begin
         fill_in = '0;
      end else if (take && (fill_ff < kk_ff)) begin
         fill_in = fill_ff + CW'(1);
      end
   end

   assign cnt_label = near_label_ff[cnt_idx_ff[IW-1:0]];

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         neighbor_count_ff <= knn_pkg::NC_RESET;
         points_ff         <= '0;
         fill_ff           <= '0;
         rd_vld_ff         <= 1'b0;
         mag_vld_ff        <= 1'b0;
         sq_vld_ff         <= 1'b0;
         dist_vld_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (csr_write) begin
            neighbor_count_ff <= csr_neighbor_count;
         end
         points_ff    <= points_in;
         fill_ff      <= fill_in;
         rd_vld_ff    <= cmd.scan;
         mag_vld_ff   <= rd_vld_ff;
         sq_vld_ff    <= mag_vld_ff;
         dist_vld_ff  <= sq_vld_ff;
         rsp_valid_ff <= cmd.finish;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      scan_idx_ff <= scan_idx_in;
      if (cmd.query) begin
         qx_ff      <= req_coord_x;
         qy_ff      <= req_coord_y;
         kk_ff      <= kk_in;
         cnt_idx_ff <= '0;
         red_ff     <= '0;
         blue_ff    <= '0;
      end else if (cmd.count) begin
         cnt_idx_ff <= cnt_idx_ff + CW'(1);
         if (cnt_label == knn_pkg::LABEL_RED) begin
            red_ff <= red_ff + CW'(1);
         end else if (cnt_label == knn_pkg::LABEL_BLUE) begin
            blue_ff <= blue_ff + CW'(1);
         end
      end
      mag_x_ff      <= mag_x_in;
      mag_y_ff      <= mag_y_in;
      mag_label_ff  <= rd_data[ENT_W-1:2*COORD_WIDTH];
      sq_x_ff       <= mag_x_ff * mag_x_ff;
      sq_y_ff       <= mag_y_ff * mag_y_ff;
      sq_label_ff   <= mag_label_ff;
      dist_ff       <= {1'b0, sq_x_ff} + {1'b0, sq_y_ff};
      dist_label_ff <= sq_label_ff;
      for (int j = 0; j < MAX_K; j++) begin
         near_dist_ff[j]  <= near_dist_in[j];
         near_label_ff[j] <= near_label_in[j];
      end
      if (cmd.finish) begin
         rsp_class_ff <= (red_ff > blue_ff) ? knn_pkg::CLASS_RED : knn_pkg::CLASS_BLUE;
         rsp_red_ff   <= knn_pkg::VOTE_W'(red_ff);
         rsp_blue_ff  <= knn_pkg::VOTE_W'(blue_ff);
      end
   end

   // Status to the controller.
   assign status.store_empty = (points_ff == '0);
   assign status.scan_last   = (PW'(scan_idx_ff) == points_ff - PW'(1));
   assign status.pipe_busy   = rd_vld_ff || mag_vld_ff || sq_vld_ff || dist_vld_ff;
   assign status.count_done  = (cnt_idx_ff == fill_ff);

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_decided_class = rsp_class_ff;
   assign rsp_red_votes     = rsp_red_ff;
   assign rsp_blue_votes    = rsp_blue_ff;

endmodule

>>> hdl/knn_two_class_vote.sv
// Two-class k-nearest-neighbor vote, top level.
// Depends on knn_pkg, knn_ctrl, knn_datapath and knn_ram.
//
// A load request (req_type = 0) writes one training point into the store;
// busy stays low, so loads can follow back to back, and a load into a full
// store is dropped. A query request (req_type = 1) raises busy and scans the
// store one point per cycle through the single read port of the point RAM,
// feeding a four-stage distance pipeline and a sorted list of the k nearest
// points. Then the list is counted one entry per cycle. A query holds busy while
// it scans the stored points, drains the pipeline, counts the listed neighbors
// and latches the answer; with an empty store it skips the scan. The answer
// appears on the rsp_ ports for one cycle with rsp_valid high, in the first cycle
// after busy falls, and must be taken then; the receiver cannot stall. Each answer
// empties the store. The user must write the k register over csr_ only while
// no query is in flight; the block does not enforce this; csr_ is always ready.
module knn_two_class_vote #(
   parameter int MAX_POINTS  = 256,
   parameter int MAX_K       = 16,
   parameter int COORD_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_type,
   input  logic signed [COORD_WIDTH-1:0] req_coord_x,
   input  logic signed [COORD_WIDTH-1:0] req_coord_y,
   input  logic [knn_pkg::LABEL_W-1:0]   req_class_label,
   output logic                          rsp_valid,
   output logic                          rsp_decided_class,
   output logic [knn_pkg::VOTE_W-1:0]    rsp_red_votes,
   output logic [knn_pkg::VOTE_W-1:0]    rsp_blue_votes,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [knn_pkg::NC_W-1:0]      csr_neighbor_count
);

   knn_pkg::knn_cmd_type    cmd;
   knn_pkg::knn_status_type status;

   assign csr_ready = 1'b1;

   // Controller.
   knn_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_type (req_type),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy)
   );

   // Datapath.
   knn_datapath #(
      .MAX_POINTS  (MAX_POINTS),
      .MAX_K       (MAX_K),
      .COORD_WIDTH (COORD_WIDTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_coord_x        (req_coord_x),
      .req_coord_y        (req_coord_y),
      .req_class_label    (req_class_label),
      .csr_write          (csr_valid && csr_ready),
      .csr_neighbor_count (csr_neighbor_count),
      .rsp_valid          (rsp_valid),
      .rsp_decided_class  (rsp_decided_class),
      .rsp_red_votes      (rsp_red_votes),
      .rsp_blue_votes     (rsp_blue_votes)
   );

   // A query request always takes the block out of idle.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_type == knn_pkg::REQ_QUERY)) |=> busy)
      else $error("query request did not raise busy");

   // Each query gives a single one-cycle answer.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("answer strobe held for more than one cycle");

   // The answer is red exactly on a strict red majority.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_decided_class ==
         ((rsp_red_votes > rsp_blue_votes) ? knn_pkg::CLASS_RED : knn_pkg::CLASS_BLUE)))
      else $error("answer does not match the vote counts");

   // No more votes than list entries.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((32'(rsp_red_votes) + 32'(rsp_blue_votes)) <= 32'(MAX_K)))
      else $error("vote counts exceed the neighbor list depth");

endmodule
